// File: sv/derq_pkg.sv
// derq_pkg: shared types and constants for the disk elevator request queue
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps
package derq_pkg;
  localparam int QueueDepth   = 16;
  localparam int CylinderBits = 16;
  localparam int TagBits      = 8;
  localparam int IdxBits      = $clog2(QueueDepth);
  localparam int CntBits      = $clog2(QueueDepth + 1);

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_SWAP  = 2'd0;
  localparam kind_t KIND_READ  = 2'd1;
  localparam kind_t KIND_WRITE = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;
  localparam status_t ST_INCON = 2'd3;

  typedef struct packed {
    logic [TagBits-1:0]      tag;
    kind_t                   kind;
    logic [CylinderBits-1:0] cyl;
    logic                    up;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SWSCAN, S_RDSCAN, S_RDSEC, S_SHIFT, S_WRITE, S_POPRD, S_POP,
    S_POPDIR, S_DONE
  } state_t;

  // control from the sequencer to the slot store
  typedef struct packed {
    logic                   rd_en;
    logic [IdxBits-1:0]     rd_addr;
    logic                   wr_en;
    logic [IdxBits-1:0]     wr_addr;
    entry_t                 wr_data;
  } store_ctl_t;
endpackage

// File: sv/disk_elevator_request_queue.sv
// disk_elevator_request_queue: elevator ordered disk request queue, top level
// depends on derq_pkg, derq_seq, derq_store
//
// channel  dir  tdata fields (low bit first)                 tuser
// in_      in   request_tag[7:0] request_kind[9:8]           opcode
//               cylinder[25:10], zero fill to 32
// out_     out  out_tag[7:0] out_kind[9:8] out_cylinder[25:10] status[1:0]
//               queue_count[30:26], zero fill to 32
//
// one request at a time; the sequencer walks the slots with one store port
// insert: at worst a backward scan of the whole queue followed by shifting
// most of it up one slot
// remove: reads the head, moves the rest down one slot; the result is registered
// in_tready is high while no request is in flight; a held result stalls only the
// last sequencer step, so the next request can be taken meanwhile
// synchronous active-low reset empties the queue; slot contents stay undefined
`timescale 1ns / 1ps
module disk_elevator_request_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // request_tag, request_kind, cylinder
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_tag, out_kind, out_cylinder, queue_count
  output logic [1:0]  out_tuser   // status
);
  import derq_pkg::*;

  store_ctl_t               ctl;
  entry_t                   rd_data;
  entry_t                   res_entry;
  status_t                  res_status;
  logic [CntBits-1:0]       res_count;
  logic                     done;
  logic                     res_ready;
  logic                     take;
  logic                     busy_r, busy_nxt;
  logic                     start;
  // one-cycle start pulse after capture
  logic                     op_pending_done_r;
  // captured request
  logic                     op_r;
  logic [TagBits-1:0]       tag_r;
  kind_t                    kind_r;
  logic [CylinderBits-1:0]  cyl_r;
  // output register
  logic                     ovalid_r, ovalid_nxt;
  logic [31:0]              odata_r;
  status_t                  ostat_r;

  assign in_tready = !busy_r;
  assign start     = busy_r && !op_pending_done_r;
  // output register free or emptying this cycle
  assign res_ready = !ovalid_r || out_tready;
  assign take      = done && res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r            <= 1'b0;
      ovalid_r          <= 1'b0;
      op_pending_done_r <= 1'b0;
    end else begin
      busy_r            <= busy_nxt;
      ovalid_r          <= ovalid_nxt;
      op_pending_done_r <= busy_nxt && (busy_r || (in_tvalid && in_tready))
                           && busy_r;
    end
    if (in_tvalid && in_tready) begin
      op_r   <= in_tuser;
      tag_r  <= in_tdata[TagBits-1:0];
      kind_r <= in_tdata[TagBits+1:TagBits];
      cyl_r  <= in_tdata[TagBits+2+CylinderBits-1:TagBits+2];
    end
    if (take) begin
      odata_r <= {1'b0, res_count, res_entry.cyl, res_entry.kind, res_entry.tag};
      ostat_r <= res_status;
    end
  end

  always_comb begin
    busy_nxt   = busy_r;
    ovalid_nxt = ovalid_r;
    if (in_tvalid && in_tready) busy_nxt = 1'b1;
    if (take) begin
      busy_nxt   = 1'b0;
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ostat_r;

  derq_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .op_remove  (op_r),
    .req_tag    (tag_r),
    .req_kind   (kind_r),
    .req_cyl    (cyl_r),
    .rd_data    (rd_data),
    .res_ready  (res_ready),
    .ctl        (ctl),
    .done       (done),
    .res_status (res_status),
    .res_entry  (res_entry),
    .res_count  (res_count)
  );

  derq_store u_store (
    .clk     (clk),
    .ctl     (ctl),
    .rd_data (rd_data)
  );

`ifndef NO_ASSERTIONS
  // a result is produced only while a request is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> busy_r) else $error("result without request");
  // a stalled response holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)
                                     && $stable(out_tuser)))
    else $error("response changed while stalled");
  // count never exceeds the depth
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    res_count <= CntBits'(QueueDepth)) else $error("count overflow");
`endif
endmodule

// File: sv/derq_store.sv
// derq_store: slot store of queue entries, one write and one registered read
// depends on derq_pkg
`timescale 1ns / 1ps
module derq_store (
  input  logic                clk,
  input  derq_pkg::store_ctl_t ctl,
  output derq_pkg::entry_t    rd_data
);
  import derq_pkg::*;
  entry_t mem [QueueDepth];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end
endmodule

// File: sv/derq_seq.sv
// derq_seq: sequencer that scans, shifts and pops slots through one store port
// depends on derq_pkg
`timescale 1ns / 1ps
module derq_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          op_remove,
  input  logic [derq_pkg::TagBits-1:0]  req_tag,
  input  derq_pkg::kind_t               req_kind,
  input  logic [derq_pkg::CylinderBits-1:0] req_cyl,
  input  derq_pkg::entry_t              rd_data,
  input  logic                          res_ready,
  output derq_pkg::store_ctl_t          ctl,
  output logic                          done,
  output derq_pkg::status_t             res_status,
  output derq_pkg::entry_t              res_entry,
  output logic [derq_pkg::CntBits-1:0]  res_count
);
  import derq_pkg::*;

  state_t                  state_r, state_nxt;
  logic [CntBits-1:0]      count_r, count_nxt;
  logic                    sweep_r, sweep_nxt;
  logic [IdxBits-1:0]      ptr_r, ptr_nxt;     // scan / shift address
  logic [IdxBits-1:0]      pos_r, pos_nxt;     // insert slot
  logic                    dir_r, dir_nxt;
  logic                    up_r, up_nxt;
  status_t                 st_r, st_nxt;
  entry_t                  head_r, head_nxt;
  logic                    pend_r, pend_nxt;   // read data valid for the shift or pop step
  logic [IdxBits-1:0]      last;

  assign last       = IdxBits'(count_r - CntBits'(1));
  assign res_status = st_r;
  assign res_entry  = head_r;
  assign res_count  = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      sweep_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      sweep_r <= sweep_nxt;
      pend_r  <= pend_nxt;
    end
    ptr_r  <= ptr_nxt;
    pos_r  <= pos_nxt;
    dir_r  <= dir_nxt;
    up_r   <= up_nxt;
    st_r   <= st_nxt;
    head_r <= head_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    sweep_nxt = sweep_r;
    ptr_nxt   = ptr_r;
    pos_nxt   = pos_r;
    dir_nxt   = dir_r;
    up_nxt    = up_r;
    st_nxt    = st_r;
    head_nxt  = head_r;
    pend_nxt  = 1'b0;
    done      = 1'b0;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          st_nxt   = ST_OK;
          head_nxt = '0;
          if (op_remove) begin
            if (count_r == '0) begin
              st_nxt    = ST_EMPTY;
              state_nxt = S_DONE;
            end else begin
              ctl.rd_en   = 1'b1;
              ctl.rd_addr = '0;
              ptr_nxt     = '0;
              pend_nxt    = 1'b1;
              state_nxt   = S_POPRD;
            end
          end else if (count_r == CntBits'(QueueDepth)) begin
            st_nxt    = ST_FULL;
            state_nxt = S_DONE;
          end else if (count_r == '0) begin
            pos_nxt   = '0;
            up_nxt    = 1'b1;
            sweep_nxt = 1'b1;
            state_nxt = S_WRITE;
          end else if (req_kind == KIND_SWAP) begin
            ctl.rd_en = 1'b1;
            ctl.rd_addr = '0;
            ptr_nxt   = '0;
            pend_nxt  = 1'b1;
            state_nxt = S_SWSCAN;
          end else if (req_kind != KIND_READ) begin
            pos_nxt   = IdxBits'(count_r);
            up_nxt    = 1'b0;
            ptr_nxt   = IdxBits'(count_r);
            state_nxt = S_SHIFT;
          end else if (count_r == CntBits'(1)) begin
            sweep_nxt = 1'b1;
            up_nxt    = 1'b1;
            pos_nxt   = IdxBits'(1);
            ptr_nxt   = IdxBits'(count_r);
            state_nxt = S_SHIFT;
          end else begin
            ctl.rd_en   = 1'b1;
            ctl.rd_addr = last;
            ptr_nxt     = last;
            pend_nxt    = 1'b1;
            state_nxt   = S_RDSCAN;
          end
        end
      end
      // forward scan for the end of the swap run
      S_SWSCAN: begin
        if (rd_data.kind != KIND_SWAP || ptr_r == last) begin
          pos_nxt = (rd_data.kind != KIND_SWAP && ptr_r != '0) ? ptr_r
                                                               : ptr_r + 1'b1;
          if (rd_data.kind != KIND_SWAP && ptr_r == '0) pos_nxt = IdxBits'(1);
          up_nxt    = 1'b0;
          ptr_nxt   = IdxBits'(count_r);
          state_nxt = S_SHIFT;
        end else begin
          ctl.rd_en   = 1'b1;
          ctl.rd_addr = ptr_r + 1'b1;
          ptr_nxt     = ptr_r + 1'b1;
        end
      end
      // backward scan for the last read, stopping before the head
      S_RDSCAN: begin
        if (rd_data.kind == KIND_SWAP) begin
          sweep_nxt = 1'b1;
          up_nxt    = 1'b1;
          pos_nxt   = ptr_r + 1'b1;
          ptr_nxt   = IdxBits'(count_r);
          state_nxt = S_SHIFT;
        end else if (rd_data.kind == KIND_READ) begin
          if (sweep_r == rd_data.up) begin
            if (!sweep_r && req_cyl <= rd_data.cyl) up_nxt = 1'b0;
            else if (sweep_r && req_cyl >= rd_data.cyl) up_nxt = 1'b1;
            else up_nxt = ~sweep_r;
            pos_nxt   = ptr_r + 1'b1;
            ptr_nxt   = IdxBits'(count_r);
            state_nxt = S_SHIFT;
          end else begin
            dir_nxt   = rd_data.up;
            up_nxt    = rd_data.up;
            state_nxt = S_RDSEC;
            // same entry is tested again as the first step of the sorted scan
            ctl.rd_en   = 1'b1;
            ctl.rd_addr = ptr_r;
          end
        end else if (ptr_r == IdxBits'(1)) begin
          sweep_nxt = 1'b1;
          up_nxt    = 1'b1;
          pos_nxt   = IdxBits'(1);
          ptr_nxt   = IdxBits'(count_r);
          state_nxt = S_SHIFT;
        end else begin
          ctl.rd_en   = 1'b1;
          ctl.rd_addr = ptr_r - 1'b1;
          ptr_nxt     = ptr_r - 1'b1;
        end
      end
      // sorted scan through the second sweep
      S_RDSEC: begin
        if (rd_data.kind != KIND_READ || rd_data.up != dir_r ||
            (dir_r ? (rd_data.cyl <= req_cyl) : (rd_data.cyl >= req_cyl))) begin
          pos_nxt   = ptr_r + 1'b1;
          ptr_nxt   = IdxBits'(count_r);
          state_nxt = S_SHIFT;
        end else if (ptr_r == IdxBits'(1)) begin
          st_nxt    = ST_INCON;
          pos_nxt   = IdxBits'(count_r);
          ptr_nxt   = IdxBits'(count_r);
          state_nxt = S_SHIFT;
        end else begin
          ctl.rd_en   = 1'b1;
          ctl.rd_addr = ptr_r - 1'b1;
          ptr_nxt     = ptr_r - 1'b1;
        end
      end
      // move entries up one slot, each with a read then a write
      S_SHIFT: begin
        if (ptr_r == pos_r) begin
          state_nxt = S_WRITE;
        end else if (!pend_r) begin
          ctl.rd_en   = 1'b1;
          ctl.rd_addr = ptr_r - 1'b1;
          pend_nxt    = 1'b1;
        end else begin
          ctl.wr_en   = 1'b1;
          ctl.wr_addr = ptr_r;
          ctl.wr_data = rd_data;
          ptr_nxt     = ptr_r - 1'b1;
        end
      end
      // the head of an empty queue keeps the raw kind, elsewhere kind 3 is a write
      S_WRITE: begin
        ctl.wr_en        = 1'b1;
        ctl.wr_addr      = pos_r;
        ctl.wr_data.tag  = req_tag;
        ctl.wr_data.kind = (count_r == '0 || req_kind == KIND_READ ||
                            req_kind == KIND_SWAP) ? req_kind : KIND_WRITE;
        ctl.wr_data.cyl  = req_cyl;
        ctl.wr_data.up   = up_r;
        count_nxt        = count_r + 1'b1;
        state_nxt        = S_DONE;
      end
      S_POPRD: begin
        head_nxt.tag  = rd_data.tag;
        head_nxt.kind = rd_data.kind;
        head_nxt.cyl  = rd_data.cyl;
        head_nxt.up   = 1'b0;
        state_nxt     = S_POP;
      end
      // move entries down one slot
      S_POP: begin
        if (CntBits'(ptr_r) + CntBits'(1) >= count_r) begin
          count_nxt = count_r - 1'b1;
          if (count_r >= CntBits'(3)) begin
            ctl.rd_en   = 1'b1;
            ctl.rd_addr = IdxBits'(1);
            state_nxt   = S_POPDIR;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (!pend_r) begin
          ctl.rd_en   = 1'b1;
          ctl.rd_addr = ptr_r + 1'b1;
          pend_nxt    = 1'b1;
        end else begin
          ctl.wr_en   = 1'b1;
          ctl.wr_addr = ptr_r;
          ctl.wr_data = rd_data;
          ptr_nxt     = ptr_r + 1'b1;
        end
      end
      S_POPDIR: begin
        if (rd_data.kind == KIND_READ) sweep_nxt = rd_data.up;
        state_nxt = S_DONE;
      end
      // result offered until the output register can take it
      S_DONE: begin
        done = 1'b1;
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// File: sim/derq_checker.sv
// derq_checker: watches both channels of the disk elevator request queue,
// predicts each response and compares it; depends on derq_pkg
`timescale 1ns / 1ps
module derq_checker
  import derq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          fail_count,
  output int          pending_count
);
  typedef struct packed {
    status_t                 status;
    logic [TagBits-1:0]      tag;
    kind_t                   kind;
    logic [CylinderBits-1:0] cyl;
    logic [4:0]              count;
  } resp_t;

  entry_t q_slot [QueueDepth];
  int     q_count;
  logic   q_sweep_up;
  resp_t  resp_fifo[$];

  assign pending_count = resp_fifo.size();

  // shift entries up and drop the new one right after pos
  function automatic void slot_insert_after(int pos, entry_t e);
    for (int i = q_count; i > pos + 1; i--) q_slot[i] = q_slot[i-1];
    q_slot[pos+1] = e;
    q_count++;
  endfunction

  function automatic status_t queue_insert(entry_t e);
    int   t;
    logic dir;
    if (q_count == 0) begin
      e.up = 1'b1;
      q_slot[0] = e;
      q_sweep_up = 1'b1;
      q_count = 1;
      return ST_OK;
    end
    if (e.kind == KIND_SWAP) begin
      t = 0;
      for (int a = 0; a < q_count; a++) begin
        if (q_slot[a].kind != KIND_SWAP) break;
        t = a;
      end
      e.up = 1'b0;
      slot_insert_after(t, e);
      return ST_OK;
    end
    if (e.kind != KIND_READ) begin
      e.kind = KIND_WRITE;
      e.up = 1'b0;
      slot_insert_after(q_count - 1, e);
      return ST_OK;
    end
    for (t = q_count - 1; t != 0; t--) begin
      if (q_slot[t].kind == KIND_SWAP) begin
        q_sweep_up = 1'b1;
        e.up = 1'b1;
        slot_insert_after(t, e);
        return ST_OK;
      end
      if (q_slot[t].kind == KIND_READ) break;
    end
    if (t == 0) begin
      // no read section yet, open one going up
      q_sweep_up = 1'b1;
      e.up = 1'b1;
      slot_insert_after(0, e);
      return ST_OK;
    end
    if (q_sweep_up == q_slot[t].up) begin
      if (!q_sweep_up && e.cyl <= q_slot[t].cyl) e.up = 1'b0;
      else if (q_sweep_up && e.cyl >= q_slot[t].cyl) e.up = 1'b1;
      else e.up = !q_sweep_up;
      slot_insert_after(t, e);
      return ST_OK;
    end
    dir = q_slot[t].up;
    e.up = dir;
    for (; t != 0; t--) begin
      if (q_slot[t].kind != KIND_READ || q_slot[t].up != dir) break;
      if (dir ? (q_slot[t].cyl <= e.cyl) : (q_slot[t].cyl >= e.cyl)) break;
    end
    if (t == 0) begin
      // second sweep ran into the head
      slot_insert_after(q_count - 1, e);
      return ST_INCON;
    end
    slot_insert_after(t, e);
    return ST_OK;
  endfunction

  function automatic resp_t queue_step(logic op, logic [31:0] d);
    resp_t  r;
    entry_t e;
    r = '0;
    e.tag = d[7:0];
    e.kind = d[9:8];
    e.cyl = d[25:10];
    e.up = 1'b0;
    if (!op) begin
      if (q_count >= QueueDepth) r.status = ST_FULL;
      else r.status = queue_insert(e);
    end else if (q_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.tag = q_slot[0].tag;
      r.kind = q_slot[0].kind;
      r.cyl = q_slot[0].cyl;
      for (int i = 1; i < q_count; i++) q_slot[i-1] = q_slot[i];
      q_count--;
      if (q_count >= 2 && q_slot[1].kind == KIND_READ) q_sweep_up = q_slot[1].up;
    end
    r.count = 5'(q_count);
    return r;
  endfunction

  always @(posedge clk) begin
    resp_t want, got;
    if (!rst_n) begin
      q_count <= 0;
      q_sweep_up <= 1'b0;
      fail_count <= 0;
      resp_fifo.delete();
    end else begin
      if (in_tvalid && in_tready) resp_fifo.push_back(queue_step(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got.status = out_tuser;
        got.tag = out_tdata[7:0];
        got.kind = out_tdata[9:8];
        got.cyl = out_tdata[25:10];
        got.count = out_tdata[30:26];
        if (resp_fifo.size() == 0) begin
          $display("%0t: unexpected response %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = resp_fifo.pop_front();
          if (want != got || out_tdata[31] !== 1'b0) begin
            $display("%0t: mismatch exp st=%0d tag=%h kind=%0d cyl=%h cnt=%0d",
                     $time, want.status, want.tag, want.kind, want.cyl, want.count);
            $display("%0t:          act st=%0d tag=%h kind=%0d cyl=%h cnt=%0d",
                     $time, got.status, got.tag, got.kind, got.cyl, got.count);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// File: sim/tb_disk_elevator_request_queue.sv
// tb_disk_elevator_request_queue: stimulus and verdict for the request queue
// depends on derq_pkg, derq_checker and the block's RTL
`timescale 1ns / 1ps
module tb_disk_elevator_request_queue;
  import derq_pkg::*;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, in_tuser;
  logic [31:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  int          fail_count, pending_count;
  int          cycle_count;
  bit          hold_off;      // long receiver stall requested
  bit          stall_mode;    // receiver stall pattern on or off

  localparam int CycleLimit = 400000;

  disk_elevator_request_queue u_top (.*);
  derq_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls in stretches, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_off) out_tready <= 1'b0;
    else if (stall_mode) out_tready <= ($urandom_range(0, 2) != 0);
    else out_tready <= 1'b1;
  end

  always @(posedge clk) if ($urandom_range(0, 63) == 0) stall_mode <= !stall_mode;

  // offer one request, wait for it to be taken, then drop valid for a cycle
  task automatic send_request(logic op, logic [7:0] tag, kind_t kind, logic [15:0] cyl);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {6'd0, cyl, kind, tag};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_responses();
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // random request mix biased toward reads so both sweeps get exercised
  task automatic random_request(int remove_weight);
    kind_t       k;
    logic [15:0] cyl;
    int          pick;
    pick = $urandom_range(0, 9);
    k = (pick < 2) ? KIND_SWAP : (pick < 7) ? KIND_READ : (pick < 9) ? KIND_WRITE : 2'd3;
    cyl = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    send_request($urandom_range(0, 99) < remove_weight, 8'($urandom), k, cyl);
  endtask

  initial begin
    int burst, gap;
    cycle_count = 0;
    rst_n = 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= 1'b0;
    in_tdata <= '0;
    hold_off = 1'b0;
    stall_mode = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty remove, head insert, field extremes, every kind
    send_request(1'b1, 8'h00, KIND_SWAP, 16'h0000);
    send_request(1'b0, 8'hff, KIND_READ, 16'hffff);
    send_request(1'b0, 8'h00, KIND_READ, 16'h0000);   // read opens a section
    send_request(1'b0, 8'h5a, KIND_READ, 16'h8000);
    send_request(1'b0, 8'ha5, KIND_READ, 16'h0100);
    send_request(1'b0, 8'h11, KIND_SWAP, 16'h1234);
    send_request(1'b0, 8'h22, KIND_WRITE, 16'h4321);
    send_request(1'b0, 8'h33, 2'd3, 16'h7fff);        // kind 3 stored as write
    send_request(1'b0, 8'h44, KIND_READ, 16'h0050);
    send_request(1'b1, 8'h00, KIND_SWAP, 16'h0000);
    send_request(1'b1, 8'h00, KIND_SWAP, 16'h0000);
    send_request(1'b0, 8'h55, KIND_READ, 16'h0010);
    // fill the queue then overflow it
    for (int i = 0; i < 10; i++) send_request(1'b0, 8'(i), KIND_READ, 16'(i * 37));
    send_request(1'b0, 8'h66, KIND_WRITE, 16'hffff);
    for (int i = 0; i < 17; i++) send_request(1'b1, 8'h00, KIND_SWAP, 16'h0000);
    drain_responses();

    // long receiver hold-off while requests keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 8; i++) random_request(20);
    join
    drain_responses();

    // random bursts with gaps; remove weight varies so queue fills and empties
    for (int n = 0; n < 1100; ) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++, n++)
        random_request((n / 200) % 2 ? 60 : 35);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      repeat (gap) @(posedge clk);
      if ($urandom_range(0, 15) == 0) drain_responses();
    end

    drain_responses();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// File: disk_elevator_request_queue.f
sv/derq_pkg.sv
sv/derq_store.sv
sv/derq_seq.sv
sv/disk_elevator_request_queue.sv
sim/derq_checker.sv
sim/tb_disk_elevator_request_queue.sv
